// ----- rtl/alss_pkg.sv -----
// alss_pkg: shared types and constants of the adaptive low-pass setpoint shaper
// no dependencies; compiled first

package alss_pkg;

    localparam int REG_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int DT_W       = 17;
    localparam int ALPHA_BITS = 16;
    localparam int TAU_NUM_W  = 48;
    localparam int TAU_DEN_W  = 25;

    localparam logic [DT_W-1:0] DT_MIN_US = 17'd1000;
    localparam logic [DT_W-1:0] DT_MAX_US = 17'd100000;

    localparam logic [REG_W-1:0] RST_SNAP_TOL = 24'd1311;
    localparam logic [REG_W-1:0] RST_NEAR_ERR = 24'd32768;
    localparam logic [REG_W-1:0] RST_FAR_ERR  = 24'd131072;
    localparam logic [REG_W-1:0] RST_MIN_TAU  = 24'd0;
    localparam logic [REG_W-1:0] RST_NEAR_TAU = 24'd700000;
    localparam logic [REG_W-1:0] RST_FAR_TAU  = 24'd1300000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SNAP_TOL = 3'd0,
        CFG_NEAR_ERR = 3'd1,
        CFG_FAR_ERR  = 3'd2,
        CFG_MIN_TAU  = 3'd3,
        CFG_NEAR_TAU = 3'd4,
        CFG_FAR_TAU  = 3'd5
    } t_cfg_idx;

endpackage

// ----- rtl/alss_in_if.sv -----
// alss_in_if: input beat channel of the setpoint shaper
// depends on alss_pkg for the elapsed time width

interface alss_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic signed [COORD_WIDTH-1:0]  target_x;
    logic signed [COORD_WIDTH-1:0]  target_y;
    logic signed [COORD_WIDTH-1:0]  target_z;
    logic [alss_pkg::REG_W-1:0]     elapsed_us;

    modport source (output valid, operation, target_x, target_y, target_z, elapsed_us,
                    input ready);
    modport sink (input valid, operation, target_x, target_y, target_z, elapsed_us,
                  output ready);
endinterface

// ----- rtl/alss_out_if.sv -----
// alss_out_if: result beat channel of the setpoint shaper
// depends on alss_pkg for the tau width

interface alss_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_WIDTH-1:0]  setpoint_x;
    logic signed [COORD_WIDTH-1:0]  setpoint_y;
    logic signed [COORD_WIDTH-1:0]  setpoint_z;
    logic                           tau_reselected;
    logic [alss_pkg::REG_W-1:0]     current_tau_us;

    modport source (output valid, setpoint_x, setpoint_y, setpoint_z, tau_reselected,
                    current_tau_us, input ready);
    modport sink (input valid, setpoint_x, setpoint_y, setpoint_z, tau_reselected,
                  current_tau_us, output ready);
endinterface

// ----- rtl/alss_mul.sv -----
// alss_mul: shift-add serial multiplier, one multiplier bit per cycle
// stops early once the remaining multiplier bits are zero; no dependencies

module alss_mul #(
    parameter int PW = 66,
    parameter int BW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic          o_done,
    output logic [PW-1:0] o_p
);
    logic [PW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [PW-1:0] r_p;
    logic          r_busy;
    logic          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_p    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_b[0]) begin
                        r_p <= r_p + r_a;
                    end
                    r_a <= {r_a[PW-2:0], 1'b0};
                    r_b <= {1'b0, r_b[BW-1:1]};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

// ----- rtl/alss_div.sv -----
// alss_div: restoring divider, one quotient bit per cycle
// no dependencies

module alss_div #(
    parameter int NW = 48,
    parameter int DW = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_q
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_trial;
    logic          w_fit;

    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_fit ? DW'(w_trial - {1'b0, r_den}) : DW'(w_trial);
                r_num <= {r_num[NW-2:0], w_fit};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_num;
endmodule

// ----- rtl/alss_sqrt.sv -----
// alss_sqrt: integer square root, one result bit (two radicand bits) per cycle
// no dependencies

module alss_sqrt #(
    parameter int PW = 66
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [PW-1:0]   i_rad,
    output logic            o_done,
    output logic [PW/2-1:0] o_root
);
    localparam int HW = PW / 2;
    localparam int CW = $clog2(HW + 1);

    logic [PW-1:0] r_rad;
    logic [HW+1:0] r_rem;
    logic [HW-1:0] r_root;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [HW+3:0] w_rem2;
    logic [HW+3:0] w_trial;
    logic          w_fit;

    assign w_rem2  = {r_rem, r_rad[PW-1:PW-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_fit   = w_rem2 >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(HW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_fit ? (HW+2)'(w_rem2 - w_trial) : (HW+2)'(w_rem2);
                r_root <= {r_root[HW-2:0], w_fit};
                r_rad  <= {r_rad[PW-3:0], 2'b00};
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- rtl/adaptive_lowpass_setpoint_shaper_top.sv -----
// adaptive_lowpass_setpoint_shaper_top: sequencer, state and registers of the shaper
// depends on alss_pkg, alss_in_if, alss_out_if, alss_mul, alss_div, alss_sqrt

// One beat in, one beat out. A jump beat, or the first beat after reset, goes
// straight to the output step. A shaping beat runs its arithmetic one bit per
// cycle through a shared shift-add multiplier (up to eight products), a 48-step
// restoring divider (up to two quotients) and a square root that is used only
// when the target moved. A new beat is taken while the previous result still
// waits at the output.

module adaptive_lowpass_setpoint_shaper_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [alss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [alss_pkg::REG_W-1:0]    i_cfg_data,
    alss_in_if.sink                       i_item,
    alss_out_if.source                    o_res
);
    import alss_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = (2 * W + 2 > 50) ? 2 * W + 2 : 50;
    localparam int HW = PW / 2;
    localparam int BW = (W + 1 > TAU_DEN_W) ? W + 1 : TAU_DEN_W;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_CHK  = 14'b00000000000010,
        S_JSQX = 14'b00000000000100,
        S_JSQY = 14'b00000000001000,
        S_ROOT = 14'b00000000010000,
        S_TMUL = 14'b00000000100000,
        S_TDIV = 14'b00000001000000,
        S_SQX  = 14'b00000010000000,
        S_SQY  = 14'b00000100000000,
        S_SNSQ = 14'b00001000000000,
        S_ADIV = 14'b00010000000000,
        S_STX  = 14'b00100000000000,
        S_STY  = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } t_state;

    t_state           r_state;
    logic [REG_W-1:0] r_snap_tol, r_near_err, r_far_err, r_min_tau, r_near_tau, r_far_tau;
    logic [W-1:0]     r_tx, r_ty, r_tz, r_sx, r_sy, r_sz, r_lx, r_ly, r_lz;
    logic [DT_W-1:0]  r_dt;
    logic [REG_W-1:0] r_tau, r_base, r_den;
    logic             r_neg, r_primed, r_resel;
    logic [PW-1:0]    r_sum;
    logic [ALPHA_BITS-1:0] r_alpha;
    logic             r_ovalid, r_oresel;
    logic [W-1:0]     r_ox, r_oy, r_oz;
    logic [REG_W-1:0] r_otau;

    logic w_acc;
    logic [W:0] w_dxl, w_dyl, w_dxs, w_dys, w_mxl, w_myl, w_mxs, w_mys;
    logic w_changed;
    logic [DT_W-1:0] w_dt;

    logic mul_start, mul_done, div_start, div_done, sq_start, sq_done;
    logic [PW-1:0] mul_a, mul_p, sq_rad;
    logic [BW-1:0] mul_b;
    logic [TAU_NUM_W-1:0] div_num, div_q;
    logic [TAU_DEN_W-1:0] div_den;
    logic [HW-1:0] sq_root;

    logic [HW+31:0]   w_root_w;
    logic [31:0]      w_d, w_over_raw;
    logic [REG_W-1:0] w_fe2, w_span, w_over, w_m, w_tau_direct, w_tau_q;
    logic             w_le, w_direct, w_snap, w_step_neg;
    logic [REG_W:0]   w_diff, w_dmag;
    logic signed [PW:0] w_sp, w_sh;

    assign w_acc        = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        if (i_item.elapsed_us < REG_W'(DT_MIN_US)) begin
            w_dt = DT_MIN_US;
        end else if (i_item.elapsed_us > REG_W'(DT_MAX_US)) begin
            w_dt = DT_MAX_US;
        end else begin
            w_dt = DT_W'(i_item.elapsed_us);
        end
    end

    assign w_dxl = {r_tx[W-1], r_tx} - {r_lx[W-1], r_lx};
    assign w_dyl = {r_ty[W-1], r_ty} - {r_ly[W-1], r_ly};
    assign w_dxs = {r_tx[W-1], r_tx} - {r_sx[W-1], r_sx};
    assign w_dys = {r_ty[W-1], r_ty} - {r_sy[W-1], r_sy};
    assign w_mxl = w_dxl[W] ? -w_dxl : w_dxl;
    assign w_myl = w_dyl[W] ? -w_dyl : w_dyl;
    assign w_mxs = w_dxs[W] ? -w_dxs : w_dxs;
    assign w_mys = w_dys[W] ? -w_dys : w_dys;
    assign w_changed = (r_tx != r_lx) || (r_ty != r_ly) || (r_tz != r_lz);

    // tau selection from the jump distance
    assign w_root_w   = (HW+32)'(sq_root);
    assign w_d        = (w_root_w > (HW+32)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w_root_w[31:0];
    assign w_fe2      = (r_far_err < r_near_err) ? r_near_err : r_far_err;
    assign w_le       = w_d <= {8'd0, r_near_err};
    assign w_span     = w_fe2 - r_near_err;
    assign w_over_raw = w_d - {8'd0, r_near_err};
    assign w_over     = (w_over_raw > {8'd0, w_span}) ? w_span : w_over_raw[REG_W-1:0];
    assign w_direct   = w_le ? (r_near_err == '0) : (w_span == '0);
    assign w_tau_direct = w_le ? r_near_tau : r_far_tau;
    assign w_diff     = w_le ? ({1'b0, r_near_tau} - {1'b0, r_min_tau})
                             : ({1'b0, r_far_tau} - {1'b0, r_near_tau});
    assign w_dmag     = w_diff[REG_W] ? -w_diff : w_diff;
    assign w_m        = w_le ? w_d[REG_W-1:0] : w_over;
    assign w_tau_q    = div_q[REG_W-1:0];

    assign w_snap     = (r_sum <= mul_p) || (r_tau == '0);

    // floor of alpha times delta over 2^16, toward minus infinity
    assign w_step_neg = (r_state == S_STX) ? w_dxs[W] : w_dys[W];
    assign w_sp       = w_step_neg ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
    assign w_sh       = w_sp >>> ALPHA_BITS;

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        sq_start  = 1'b0;
        sq_rad    = '0;
        case (r_state)
            S_CHK: begin
                mul_start = 1'b1;
                mul_a     = w_changed ? PW'(w_mxl) : PW'(w_mxs);
                mul_b     = w_changed ? BW'(w_mxl) : BW'(w_mxs);
            end
            S_JSQX: begin
                mul_start = mul_done;
                mul_a     = PW'(w_myl);
                mul_b     = BW'(w_myl);
            end
            S_JSQY: begin
                sq_start = mul_done;
                sq_rad   = r_sum + mul_p;
            end
            S_ROOT: begin
                mul_start = sq_done;
                mul_a     = w_direct ? PW'(w_mxs) : PW'(w_m);
                mul_b     = w_direct ? BW'(w_mxs) : BW'(w_dmag);
            end
            S_TMUL: begin
                div_start = mul_done;
                div_num   = mul_p[TAU_NUM_W-1:0];
                div_den   = TAU_DEN_W'(r_den);
            end
            S_TDIV: begin
                mul_start = div_done;
                mul_a     = PW'(w_mxs);
                mul_b     = BW'(w_mxs);
            end
            S_SQX: begin
                mul_start = mul_done;
                mul_a     = PW'(w_mys);
                mul_b     = BW'(w_mys);
            end
            S_SQY: begin
                mul_start = mul_done;
                mul_a     = PW'(r_snap_tol);
                mul_b     = BW'(r_snap_tol);
            end
            S_SNSQ: begin
                div_start = mul_done && !w_snap;
                div_num   = TAU_NUM_W'({r_dt, {ALPHA_BITS{1'b0}}});
                div_den   = TAU_DEN_W'(r_tau) + TAU_DEN_W'(r_dt);
            end
            S_ADIV: begin
                mul_start = div_done;
                mul_a     = PW'(w_mxs);
                mul_b     = BW'(div_q[ALPHA_BITS-1:0]);
            end
            S_STX: begin
                mul_start = mul_done;
                mul_a     = PW'(w_mys);
                mul_b     = BW'(r_alpha);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_primed   <= 1'b0;
            r_tau      <= '0;
            r_resel    <= 1'b0;
            r_ovalid   <= 1'b0;
            r_snap_tol <= RST_SNAP_TOL;
            r_near_err <= RST_NEAR_ERR;
            r_far_err  <= RST_FAR_ERR;
            r_min_tau  <= RST_MIN_TAU;
            r_near_tau <= RST_NEAR_TAU;
            r_far_tau  <= RST_FAR_TAU;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SNAP_TOL: r_snap_tol <= i_cfg_data;
                    CFG_NEAR_ERR: r_near_err <= i_cfg_data;
                    CFG_FAR_ERR:  r_far_err  <= i_cfg_data;
                    CFG_MIN_TAU:  r_min_tau  <= i_cfg_data;
                    CFG_NEAR_TAU: r_near_tau <= i_cfg_data;
                    CFG_FAR_TAU:  r_far_tau  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_ovalid && o_res.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_tx    <= i_item.target_x;
                        r_ty    <= i_item.target_y;
                        r_tz    <= i_item.target_z;
                        r_dt    <= w_dt;
                        r_sz    <= i_item.target_z;
                        r_resel <= 1'b0;
                        if (i_item.operation || !r_primed) begin
                            r_sx     <= i_item.target_x;
                            r_sy     <= i_item.target_y;
                            r_lx     <= i_item.target_x;
                            r_ly     <= i_item.target_y;
                            r_lz     <= i_item.target_z;
                            r_primed <= 1'b1;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_state <= w_changed ? S_JSQX : S_SQX;
                end
                S_JSQX: begin
                    if (mul_done) begin
                        r_sum   <= mul_p;
                        r_state <= S_JSQY;
                    end
                end
                S_JSQY: begin
                    if (mul_done) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (sq_done) begin
                        r_lx    <= r_tx;
                        r_ly    <= r_ty;
                        r_lz    <= r_tz;
                        r_resel <= 1'b1;
                        r_base  <= w_le ? r_min_tau : r_near_tau;
                        r_neg   <= w_diff[REG_W];
                        r_den   <= w_le ? r_near_err : w_span;
                        if (w_direct) begin
                            r_tau   <= w_tau_direct;
                            r_state <= S_SQX;
                        end else begin
                            r_state <= S_TMUL;
                        end
                    end
                end
                S_TMUL: begin
                    if (mul_done) begin
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (div_done) begin
                        r_tau   <= r_neg ? r_base - w_tau_q : r_base + w_tau_q;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    if (mul_done) begin
                        r_sum   <= mul_p;
                        r_state <= S_SQY;
                    end
                end
                S_SQY: begin
                    if (mul_done) begin
                        r_sum   <= r_sum + mul_p;
                        r_state <= S_SNSQ;
                    end
                end
                S_SNSQ: begin
                    if (mul_done) begin
                        if (w_snap) begin
                            r_sx    <= r_tx;
                            r_sy    <= r_ty;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_ADIV;
                        end
                    end
                end
                S_ADIV: begin
                    if (div_done) begin
                        r_alpha <= div_q[ALPHA_BITS-1:0];
                        r_state <= S_STX;
                    end
                end
                S_STX: begin
                    if (mul_done) begin
                        r_sx    <= r_sx + w_sh[W-1:0];
                        r_state <= S_STY;
                    end
                end
                S_STY: begin
                    if (mul_done) begin
                        r_sy    <= r_sy + w_sh[W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ox     <= r_sx;
                        r_oy     <= r_sy;
                        r_oz     <= r_sz;
                        r_oresel <= r_resel;
                        r_otau   <= r_tau;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    alss_mul #(.PW(PW), .BW(BW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    alss_div #(.NW(TAU_NUM_W), .DW(TAU_DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    alss_sqrt #(.PW(PW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign o_res.valid          = r_ovalid;
    assign o_res.setpoint_x     = r_ox;
    assign o_res.setpoint_y     = r_oy;
    assign o_res.setpoint_z     = r_oz;
    assign o_res.tau_reselected = r_oresel;
    assign o_res.current_tau_us = r_otau;

    a_jump_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_item.operation || !r_primed)) |=> (r_state == S_DONE))
        else $error("jump beat did not go straight to output");

    a_primed_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_primed)
        else $error("not primed after an accepted beat");

    a_mul_done_in_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_JSQX || r_state == S_JSQY || r_state == S_TMUL ||
                      r_state == S_SQX || r_state == S_SQY || r_state == S_SNSQ ||
                      r_state == S_STX || r_state == S_STY))
        else $error("multiplier finished outside a multiply step");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside the output step");
endmodule
